FILE: sv/ptom_pkg.sv
// Shared types and constants of the price-time order matcher.
// Used by ptom_ctrl, ptom_dpath and price_time_order_matcher; no dependencies.
package ptom_pkg;

    localparam int SLOTS_PER_SIDE_DEF = 32;
    localparam int QTY_W    = 16;
    localparam int DOL_W    = 20;
    localparam int CEN_W    = 7;
    localparam int KEY_W    = DOL_W + CEN_W;
    localparam int ID_W     = 32;
    localparam int OWN_W    = 16;
    localparam int ARR_W    = 32;
    // The order kind travels in tuser, so the input word holds the side and the rest.
    localparam int IN_W     = 1 + QTY_W + DOL_W + CEN_W + ID_W + OWN_W;
    localparam int IN_BYTES = (IN_W + 7) / 8;
    localparam int OUT_W    = OWN_W + ID_W + QTY_W + DOL_W + CEN_W + 1 + 2 + 1;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic KIND_LIMIT = 1'b0;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_PARTIAL = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the incoming order
        logic scan_clear;  // reset best-candidate tracking
        logic scan_step;   // examine one slot at the scan index
        logic fill;        // apply the fill of the best slot
        logic rest;        // place the remainder in the free slot
        logic emit_fill;   // load the output register with a fill report
        logic emit_close;  // load the output register with the closing report
    } ptom_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;   // last slot has been examined
        logic found;       // a matching resting order was found
        logic rem_zero;    // incoming order fully satisfied
        logic can_rest;    // remainder of a limit order should rest
    } ptom_stat_t;

endpackage

FILE: sv/ptom_ctrl.sv
// Controller state machine of the order matcher.
// Depends on ptom_pkg; drives ptom_dpath through command and status structs.
module ptom_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                out_busy,
    input  ptom_pkg::ptom_stat_t stat,
    output ptom_pkg::ptom_cmd_t  cmd,
    output logic                idle
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DEC   = 6'b000100,
        S_FILL  = 6'b001000,
        S_CLOSE = 6'b010000,
        S_WAIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.load       = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (!stat.found || stat.rem_zero) begin
                    state_next = S_CLOSE;
                end else if (!out_busy) begin
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                cmd.fill       = 1'b1;
                cmd.emit_fill  = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next     = S_SCAN;
            end
            S_CLOSE: begin
                if (!out_busy) begin
                    cmd.emit_close = 1'b1;
                    cmd.rest       = stat.can_rest;
                    state_next     = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign idle = (state_reg == S_IDLE);

    a_fill_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill |-> !out_busy)
        else $error("fill issued while output register full");
    a_load_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> $past(state_next == S_IDLE) || state_reg == S_IDLE)
        else $error("load outside idle");
    a_close_to_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_close |=> state_reg == S_WAIT)
        else $error("closing report not followed by wait");

endmodule

FILE: sv/ptom_dpath.sv
// Datapath of the order matcher: the book, the sequential best-slot scan,
// fill and rest updates and the output register. Depends on ptom_pkg.
module ptom_dpath #(
    parameter int SLOTS_PER_SIDE = ptom_pkg::SLOTS_PER_SIDE_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ptom_pkg::ptom_cmd_t         cmd,
    output ptom_pkg::ptom_stat_t        stat,
    input  logic                        in_side,
    input  logic                        in_kind,
    input  logic [ptom_pkg::QTY_W-1:0]  in_qty,
    input  logic [ptom_pkg::DOL_W-1:0]  in_dol,
    input  logic [ptom_pkg::CEN_W-1:0]  in_cen,
    input  logic [ptom_pkg::ID_W-1:0]   in_id,
    input  logic [ptom_pkg::OWN_W-1:0]  in_own,
    input  logic                        out_take,
    output logic                        out_valid,
    output logic [ptom_pkg::OUT_W-1:0]  out_data,
    output logic                        out_last
);

    localparam int DEPTH = 2 * SLOTS_PER_SIDE;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Slot contents sit in a memory read one slot per scan step.
    logic                        mem_side  [DEPTH];
    logic [ptom_pkg::ID_W-1:0]   mem_id    [DEPTH];
    logic [ptom_pkg::OWN_W-1:0]  mem_own   [DEPTH];
    logic [ptom_pkg::KEY_W-1:0]  mem_key   [DEPTH];
    logic [ptom_pkg::QTY_W-1:0]  mem_rem   [DEPTH];
    logic [ptom_pkg::ARR_W-1:0]  mem_arr   [DEPTH];
    logic [DEPTH-1:0]            valid_reg;

    logic                        side_reg, kind_reg;
    logic [ptom_pkg::QTY_W-1:0]  qty_reg, rem_reg;
    logic [ptom_pkg::KEY_W-1:0]  lim_reg;
    logic [ptom_pkg::ID_W-1:0]   id_reg;
    logic [ptom_pkg::OWN_W-1:0]  own_reg;
    logic [ptom_pkg::ARR_W-1:0]  arrival_reg;

    logic [CNT_W-1:0]            idx_reg;    // issue index
    logic                        rd_vld_reg; // read data valid
    logic [IDX_W-1:0]            rd_idx_reg;
    logic                        rd_side_reg;
    logic [ptom_pkg::ID_W-1:0]   rd_id_reg;
    logic [ptom_pkg::KEY_W-1:0]  rd_key_reg;
    logic [ptom_pkg::ARR_W-1:0]  rd_arr_reg;
    logic [ptom_pkg::OWN_W-1:0]  rd_own_reg;
    logic [ptom_pkg::QTY_W-1:0]  rd_rem_reg;

    logic                        found_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [ptom_pkg::KEY_W-1:0]  best_key_reg;
    logic [ptom_pkg::ARR_W-1:0]  best_age_reg;
    logic [ptom_pkg::OWN_W-1:0]  best_own_reg;
    logic [ptom_pkg::ID_W-1:0]   best_id_reg;
    logic [ptom_pkg::QTY_W-1:0]  best_rem_reg;

    logic [CNT_W-1:0]            buy_cnt_reg, sell_cnt_reg;
    logic [CNT_W-1:0]            side_cnt;
    logic                        free_any;
    logic [IDX_W-1:0]            free_idx;

    logic                        out_valid_reg, out_last_reg;
    logic [ptom_pkg::OUT_W-1:0]  out_data_reg;

    logic                        rd_en;
    logic                        cand;
    logic [ptom_pkg::ARR_W-1:0]  cand_age;
    logic                        better;
    logic                        rest_full;
    logic                        rest_now;
    logic [ptom_pkg::QTY_W-1:0]  fill_qty;
    logic                        fill_all;
    logic [1:0]                  close_state;

    assign rd_en = cmd.scan_step && (idx_reg < CNT_W'(DEPTH));

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_side_reg <= mem_side[idx_reg[IDX_W-1:0]];
            rd_id_reg   <= mem_id[idx_reg[IDX_W-1:0]];
            rd_key_reg  <= mem_key[idx_reg[IDX_W-1:0]];
            rd_arr_reg  <= mem_arr[idx_reg[IDX_W-1:0]];
            rd_own_reg  <= mem_own[idx_reg[IDX_W-1:0]];
            rd_rem_reg  <= mem_rem[idx_reg[IDX_W-1:0]];
            rd_idx_reg  <= idx_reg[IDX_W-1:0];
        end
        if (cmd.fill) begin
            mem_rem[best_idx_reg] <= best_rem_reg - fill_qty;
        end else if (rest_now) begin
            mem_side[free_idx] <= side_reg;
            mem_id[free_idx]   <= id_reg;
            mem_own[free_idx]  <= own_reg;
            mem_key[free_idx]  <= lim_reg;
            mem_rem[free_idx]  <= rem_reg;
            mem_arr[free_idx]  <= arrival_reg;
        end
    end

    // Candidate test on the registered read word.
    always_comb begin
        cand = rd_vld_reg && valid_reg[rd_idx_reg] && (rd_side_reg != side_reg)
            && (rd_id_reg != id_reg);
        if (kind_reg == ptom_pkg::KIND_LIMIT) begin
            if (side_reg == ptom_pkg::SIDE_BUY) begin
                cand = cand && (rd_key_reg <= lim_reg);
            end else begin
                cand = cand && (rd_key_reg >= lim_reg);
            end
        end
        cand_age = arrival_reg - rd_arr_reg;
        better = !found_reg
            || (side_reg == ptom_pkg::SIDE_BUY && rd_key_reg < best_key_reg)
            || (side_reg != ptom_pkg::SIDE_BUY && rd_key_reg > best_key_reg)
            || (rd_key_reg == best_key_reg && cand_age > best_age_reg);
    end

    // Lowest free slot from the valid bits; occupancy is counted per side.
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign side_cnt = (side_reg == ptom_pkg::SIDE_BUY) ? buy_cnt_reg : sell_cnt_reg;
    assign fill_all = (best_rem_reg <= rem_reg);
    assign fill_qty = fill_all ? best_rem_reg : rem_reg;
    assign rest_full = (side_cnt >= CNT_W'(SLOTS_PER_SIDE)) || !free_any;
    assign rest_now = cmd.rest && !rest_full;
    assign close_state = (rem_reg == '0) ? ptom_pkg::ST_FULL
                       : (rem_reg == qty_reg) ? ptom_pkg::ST_NONE : ptom_pkg::ST_PARTIAL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            arrival_reg   <= '0;
            out_valid_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            buy_cnt_reg   <= '0;
            sell_cnt_reg  <= '0;
        end else begin
            // A clear never coincides with a read, so this also empties the pipeline.
            rd_vld_reg <= rd_en;
            if (cmd.load) begin
                side_reg <= in_side;
                kind_reg <= in_kind;
                qty_reg  <= in_qty;
                rem_reg  <= in_qty;
                lim_reg  <= {in_dol, in_cen};
                id_reg   <= in_id;
                own_reg  <= in_own;
            end
            if (cmd.scan_clear) begin
                found_reg <= 1'b0;
                idx_reg   <= '0;
            end else begin
                if (rd_en) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (cand && better) begin
                    found_reg    <= 1'b1;
                    best_idx_reg <= rd_idx_reg;
                    best_key_reg <= rd_key_reg;
                    best_age_reg <= cand_age;
                    best_own_reg <= rd_own_reg;
                    best_id_reg  <= rd_id_reg;
                    best_rem_reg <= rd_rem_reg;
                end
            end
            if (cmd.fill) begin
                rem_reg <= rem_reg - fill_qty;
                if (fill_all) begin
                    valid_reg[best_idx_reg] <= 1'b0;
                    // The freed slot belongs to the opposite side.
                    if (side_reg == ptom_pkg::SIDE_BUY) begin
                        sell_cnt_reg <= sell_cnt_reg - 1'b1;
                    end else begin
                        buy_cnt_reg <= buy_cnt_reg - 1'b1;
                    end
                end
            end
            if (rest_now) begin
                valid_reg[free_idx] <= 1'b1;
                arrival_reg         <= arrival_reg + 1'b1;
                if (side_reg == ptom_pkg::SIDE_BUY) begin
                    buy_cnt_reg <= buy_cnt_reg + 1'b1;
                end else begin
                    sell_cnt_reg <= sell_cnt_reg + 1'b1;
                end
            end
            if (cmd.emit_fill) begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= 1'b0;
                out_data_reg  <= {1'b0, 2'b00, fill_all,
                                  best_key_reg[ptom_pkg::CEN_W-1:0],
                                  best_key_reg[ptom_pkg::KEY_W-1:ptom_pkg::CEN_W],
                                  fill_qty, best_id_reg, best_own_reg};
            end else if (cmd.emit_close) begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= 1'b1;
                out_data_reg  <= {cmd.rest && rest_full, close_state, 1'b0,
                                  {ptom_pkg::KEY_W{1'b0}}, {ptom_pkg::QTY_W{1'b0}},
                                  {ptom_pkg::ID_W{1'b0}}, {ptom_pkg::OWN_W{1'b0}}};
            end else if (out_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The scan is done once the final read word has been judged.
    assign stat.scan_done = (idx_reg == CNT_W'(DEPTH)) && !rd_vld_reg;
    assign stat.found     = found_reg;
    assign stat.rem_zero  = (rem_reg == '0);
    assign stat.can_rest  = (kind_reg == ptom_pkg::KIND_LIMIT) && (rem_reg != '0);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    a_fill_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill |-> found_reg && fill_qty != '0)
        else $error("fill without a candidate");
    a_rest_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        rest_now |-> kind_reg == ptom_pkg::KIND_LIMIT && !valid_reg[free_idx])
        else $error("rest into occupied slot");
    a_fill_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill && fill_all |=> !valid_reg[$past(best_idx_reg)])
        else $error("filled slot still valid");

endmodule

FILE: sv/price_time_order_matcher.sv
// Price-time priority order matcher over a bounded two-sided book.
// Operation: a scan reads one slot per cycle over all 2*S slots (S = SLOTS_PER_SIDE),
// then a decision state leads either to a fill, which emits a fill word and rescans,
// or to the closing word; emitting waits while the output register is full, closing word last.
// One order at a time: the next order is accepted only once the matcher is idle again,
// after the closing word is taken. Reset (synchronous) empties the book.
module price_time_order_matcher #(
    parameter int SLOTS_PER_SIDE = ptom_pkg::SLOTS_PER_SIDE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // side, order_qty, limit_dollars, limit_cents, order_ident, owner_ident
    input  logic [ptom_pkg::IN_BYTES*8-1:0]   s_tdata,
    // order_kind
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // rest_owner, rest_order, fill_qty, fill_dollars, fill_cents, rest_fully_filled,
    // incoming_state, book_full
    output logic [ptom_pkg::OUT_BYTES*8-1:0]  m_tdata,
    // is_summary
    output logic                              m_tuser,
    output logic                              m_tlast
);

    ptom_pkg::ptom_cmd_t  cmd;
    ptom_pkg::ptom_stat_t stat;
    logic                 idle;
    logic                 out_take;
    logic [ptom_pkg::OUT_W-1:0] body;
    logic                 in_fire;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;

    ptom_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_busy (m_tvalid && !m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .idle     (idle)
    );

    ptom_dpath #(.SLOTS_PER_SIDE(SLOTS_PER_SIDE)) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_side   (s_tdata[0]),
        .in_kind   (s_tuser),
        .in_qty    (s_tdata[16:1]),
        .in_dol    (s_tdata[36:17]),
        .in_cen    (s_tdata[43:37]),
        .in_id     (s_tdata[75:44]),
        .in_own    (s_tdata[91:76]),
        .out_take  (out_take),
        .out_valid (m_tvalid),
        .out_data  (body),
        .out_last  (m_tlast)
    );

    // Only the closing report is the last word, so is_summary equals last.
    assign m_tdata = {{(ptom_pkg::OUT_BYTES*8 - ptom_pkg::OUT_W){1'b0}}, body};
    assign m_tuser = m_tlast;

endmodule
